// File: design/cpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the contrast pixel counter.
// ----------------------------------------------------------------------------
package cpc_pkg;

   localparam int PIXEL_W          = 8;
   localparam int COUNT_W          = 20;
   localparam int FRAME_WIDTH_W    = 10;
   localparam int FRAME_HEIGHT_W   = 11;
   localparam int THRESHOLD_W      = 8;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 11;

   localparam int MAX_WIDTH_DEFAULT  = 512;
   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int MIN_DIM            = 2;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = FRAME_WIDTH_W'(320);
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = FRAME_HEIGHT_W'(200);
   localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RESET    = THRESHOLD_W'(128);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_CONTRAST_THRESHOLD
   } cpc_csr_type;

   // position flags of one pixel beat, worked out when it is accepted
   typedef struct packed {
      logic has_left;    // column above zero
      logic has_left2;   // column two or more
      logic has_right;   // column below the last one
      logic upper_row;   // row one or more
      logic has_up2;     // row two or more
      logic last_row;
      logic last_col;
   } cpc_flags_type;

   typedef struct packed {
      cpc_flags_type        flags;
      logic [PIXEL_W-1:0]   pixel;
      logic [PIXEL_W-1:0]   recent0;   // this row, one column back
      logic [PIXEL_W-1:0]   recent1;   // this row, two columns back
   } cpc_beat_type;

endpackage
`default_nettype wire

// File: design/cpc_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_line_store
// Two-bank row buffer: one write port, two read ports, registered reads
// (read-first on a same-address write).
// ----------------------------------------------------------------------------
module cpc_line_store #(
   parameter int ADDR_W = 10
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr_a,
   input  wire logic [ADDR_W-1:0]           rd_addr_b,
   output      logic [cpc_pkg::PIXEL_W-1:0] rd_data_a,
   output      logic [cpc_pkg::PIXEL_W-1:0] rd_data_b,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [cpc_pkg::PIXEL_W-1:0] wr_data
);
   import cpc_pkg::*;

   logic [PIXEL_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

// File: design/cpc_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_decide
// Second stage: holds the upper-row window, decides contrast for the pixels
// that become final with this beat, keeps the frame total and the result
// register.
// ----------------------------------------------------------------------------
module cpc_decide (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            beat_valid,
   input  wire cpc_pkg::cpc_beat_type           beat,
   input  wire logic [cpc_pkg::THRESHOLD_W-1:0] threshold,
   input  wire logic [cpc_pkg::PIXEL_W-1:0]     rd_right,
   input  wire logic [cpc_pkg::PIXEL_W-1:0]     rd_up,
   output      logic                            stage_ready,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [cpc_pkg::COUNT_W-1:0]     rsp_count
);
   import cpc_pkg::*;

   function automatic logic differs(input logic [PIXEL_W-1:0] a,
                                    input logic [PIXEL_W-1:0] b,
                                    input logic [THRESHOLD_W-1:0] thr);
      logic [PIXEL_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d > thr;
   endfunction

   logic                 s1_valid_ff, s1_valid_in;
   cpc_beat_type         beat_ff, beat_in;
   logic [PIXEL_W-1:0]   up_left_ff, up_left_in;
   logic [PIXEL_W-1:0]   up_center_ff, up_center_in;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 frame_end;
   logic                 fire;
   logic                 add_center, add_prev, add_last;
   logic [COUNT_W-1:0]   sum;
   cpc_flags_type        f;

   always_comb begin
      f         = beat_ff.flags;
      frame_end = f.last_row && f.last_col;
      fire      = s1_valid_ff && !(frame_end && rsp_valid_ff && !rsp_ready);

      // pixel above the current one, now that its lower neighbor is here
      add_center = f.upper_row &&
                   ((f.has_left  && differs(up_center_ff, up_left_ff, threshold)) ||
                    (f.has_right && differs(up_center_ff, rd_right, threshold)) ||
                    (f.has_up2   && differs(up_center_ff, rd_up, threshold)) ||
                    differs(up_center_ff, beat_ff.pixel, threshold));
      // last row: the left neighbor is final once its right neighbor is in
      add_prev = f.upper_row && f.last_row && f.has_left &&
                 ((f.has_left2 && differs(beat_ff.recent0, beat_ff.recent1, threshold)) ||
                  differs(beat_ff.recent0, beat_ff.pixel, threshold) ||
                  differs(beat_ff.recent0, up_left_ff, threshold));
      // last pixel of the frame decides itself
      add_last = f.upper_row && f.last_row && f.last_col &&
                 (differs(beat_ff.pixel, beat_ff.recent0, threshold) ||
                  differs(beat_ff.pixel, up_center_ff, threshold));

      sum = total_ff + COUNT_W'(add_center) + COUNT_W'(add_prev) + COUNT_W'(add_last);

      stage_ready = !s1_valid_ff || fire;

      s1_valid_in  = beat_valid ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      beat_in      = beat_valid ? beat : beat_ff;
      up_left_in   = up_left_ff;
      up_center_in = up_center_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;

      if (fire) begin
         // slide the upper window; on a last column this loads the next
         // row's first upper pixel
         up_left_in   = up_center_ff;
         up_center_in = rd_right;
         if (frame_end) begin
            total_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_count_in = sum;
         end else begin
            total_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         up_left_ff   <= '0;
         up_center_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         up_left_ff   <= up_left_in;
         up_center_ff <= up_center_in;
      end
      beat_ff      <= beat_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule
`default_nettype wire

// File: design/contrast_pixel_counter_core.sv
`default_nettype none
// Result path: last beat to the stage-two register, total to rsp once free.
// Throughput: one pixel beat per cycle; req stalls only while a finished
//   total is still waiting on rsp and the next frame end reaches stage two.
// Each beat makes one line-store access: two reads and one write in parallel.
// Reset: control, positions, total and config clear at once; the line store
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// contrast_pixel_counter_core
// Counts the pixels of a raster-order grey frame that differ from any
// 4-neighbor by more than a threshold; one total per frame.
// ----------------------------------------------------------------------------
module contrast_pixel_counter_core #(
   parameter int MAX_WIDTH  = cpc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = cpc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [cpc_pkg::PIXEL_W-1:0]     req_pixel,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [cpc_pkg::COUNT_W-1:0]     rsp_contrast_count,
   input  wire logic                            csr_write_en,
   input  wire logic [cpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cpc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import cpc_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = COL_W + 1;   // bank bit (row parity) + column

   // config registers
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic [THRESHOLD_W-1:0]    threshold_ff, threshold_in;

   // stream position and the two most recent pixels of this row
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PIXEL_W-1:0] recent0_ff, recent0_in;
   logic [PIXEL_W-1:0] recent1_ff, recent1_in;

   logic [COL_W-1:0]   last_col_idx;
   logic [ROW_W-1:0]   last_row_idx;
   logic               accept;
   cpc_flags_type      flags;
   cpc_beat_type       beat;
   logic               cur_bank;
   logic [ADDR_W-1:0]  addr_right, addr_up;
   logic [PIXEL_W-1:0] rd_right, rd_up;

   // ---- config writes; out-of-range index is dropped ----
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      threshold_in    = threshold_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:
               frame_width_in = csr_write_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:
               frame_height_in = csr_write_data[FRAME_HEIGHT_W-1:0];
            CSR_CONTRAST_THRESHOLD:
               threshold_in = csr_write_data[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- clamp width/height into [2, MAX] and keep the last index ----
   always_comb begin
      if (32'(frame_width_ff) < 32'(MIN_DIM)) begin
         last_col_idx = COL_W'(MIN_DIM - 1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         last_col_idx = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col_idx = COL_W'(frame_width_ff - FRAME_WIDTH_W'(1));
      end
      if (32'(frame_height_ff) < 32'(MIN_DIM)) begin
         last_row_idx = ROW_W'(MIN_DIM - 1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         last_row_idx = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row_idx = ROW_W'(frame_height_ff - FRAME_HEIGHT_W'(1));
      end
   end

   // ---- stage one: position flags, line-store access, position update ----
   assign accept = req_valid && req_ready;

   always_comb begin
      flags.has_left  = (col_ff != '0);
      flags.has_left2 = (col_ff > COL_W'(1));
      flags.has_right = (col_ff < last_col_idx);
      flags.upper_row = (row_ff != '0);
      flags.has_up2   = (row_ff > ROW_W'(1));
      flags.last_row  = (row_ff >= last_row_idx);
      flags.last_col  = (col_ff >= last_col_idx);

      beat.flags   = flags;
      beat.pixel   = req_pixel;
      beat.recent0 = recent0_ff;
      beat.recent1 = recent1_ff;

      // current row's bank still holds row r-2 at this column (read-first);
      // the other bank holds row r-1.
      cur_bank = row_ff[0];
      addr_up  = {cur_bank, col_ff};
      // port A fetches the upper-right pixel; on the last column it
      // prefetches column zero of this row, the next row's first upper pixel
      if (flags.last_col) begin
         addr_right = {cur_bank, COL_W'(0)};
      end else begin
         addr_right = {~cur_bank, COL_W'(col_ff + COL_W'(1))};
      end

      col_in     = col_ff;
      row_in     = row_ff;
      recent0_in = recent0_ff;
      recent1_in = recent1_ff;
      if (accept) begin
         if (flags.last_col) begin
            col_in     = '0;
            recent0_in = '0;
            recent1_in = '0;
            row_in     = flags.last_row ? '0 : ROW_W'(row_ff + ROW_W'(1));
         end else begin
            col_in     = COL_W'(col_ff + COL_W'(1));
            recent0_in = req_pixel;
            recent1_in = recent0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         threshold_ff    <= THRESHOLD_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         recent0_ff      <= '0;
         recent1_ff      <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         threshold_ff    <= threshold_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         recent0_ff      <= recent0_in;
         recent1_ff      <= recent1_in;
      end
   end

   cpc_line_store #(
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (addr_right),
      .rd_addr_b (addr_up),
      .rd_data_a (rd_right),
      .rd_data_b (rd_up),
      .wr_en     (accept),
      .wr_addr   ({cur_bank, col_ff}),
      .wr_data   (req_pixel)
   );

   // ---- stage two: decisions, frame total, result register ----
   cpc_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (accept),
      .beat        (beat),
      .threshold   (threshold_ff),
      .rd_right    (rd_right),
      .rd_up       (rd_up),
      .stage_ready (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_count   (rsp_contrast_count)
   );

endmodule
`default_nettype wire
